// ===== rtl/mbgs_pkg.sv =====
// ----------------------------------------------------------------------------
// mbgs_pkg
// Shared types and constants of the multi-branch gshare predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package mbgs_pkg;

  // Default table geometry
  localparam int ROWS_DEFAULT      = 4096;
  localparam int MAX_SLOTS_DEFAULT = 16;

  // Field widths
  localparam int PC_W      = 64;
  localparam int HIST_W    = 64;
  localparam int SLOT_W    = 4;
  localparam int MASK_W    = 16;
  localparam int STAT_W    = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 5;
  localparam int SCNT_W    = 5;
  localparam int SHIFT_W   = 2;

  // Request codes
  typedef enum logic [1:0] {
    REQ_PREDICT = 2'd0,
    REQ_UPDATE  = 2'd1,
    REQ_CLEAR   = 2'd2
  } req_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PC_SHIFT   = 1'b1;

  // Configuration reset values
  localparam logic [SCNT_W-1:0]  SLOT_COUNT_RESET = 5'd4;
  localparam logic [SHIFT_W-1:0] PC_SHIFT_RESET   = 2'd2;

  // Two-bit counter values
  localparam logic [1:0] CTR_RESET = 2'd2;
  localparam logic [1:0] CTR_MAX   = 2'd3;
  localparam logic [1:0] CTR_MIN   = 2'd0;

  localparam logic [STAT_W-1:0] STAT_MAX = '1;

endpackage

`default_nettype wire

// ===== rtl/mbgs_ram.sv =====
// ----------------------------------------------------------------------------
// mbgs_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// A read and a write to the same address in one cycle return the old data.
// ----------------------------------------------------------------------------
`default_nettype none

module mbgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/multi_branch_gshare_predictor_top.sv =====
// ----------------------------------------------------------------------------
// multi_branch_gshare_predictor_top
// Gshare pattern history table with one 2-bit counter per branch slot per row.
// ----------------------------------------------------------------------------
// Accepts one transaction per clock while in_stall is low and returns one result
// per transaction; an item waits in stage B for its row and its result is then
// registered. The row is read from a registered-read RAM in the accept cycle and
// written back (for updates) as the result is registered; a back-to-back access
// to the same row takes the just-written row from a bypass register. After reset
// the table is swept to weakly taken, one row per cycle, with in_stall high for
// the whole sweep; configuration writes are taken during that sweep. ROWS must be
// a power of two. Hit and miss counts live in flip-flops and saturate.
`default_nettype none

module multi_branch_gshare_predictor_top
  import mbgs_pkg::*;
#(
  parameter int ROWS      = ROWS_DEFAULT,
  parameter int MAX_SLOTS = MAX_SLOTS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // request channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            req_type,
  input  wire logic [PC_W-1:0]       pc,
  input  wire logic [HIST_W-1:0]     history,
  input  wire logic [SLOT_W-1:0]     slot_index,
  input  wire logic                  outcome_taken,
  input  wire logic                  prediction_correct,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [MASK_W-1:0]          taken_mask,
  output logic [STAT_W-1:0]          hit_total,
  output logic [STAT_W-1:0]          miss_total,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ROW_BITS = $clog2(ROWS);
  localparam int ROW_W    = 2 * MAX_SLOTS;
  localparam logic [SCNT_W-1:0] MAX_SLOTS_W = SCNT_W'(MAX_SLOTS);
  localparam logic [ROW_W-1:0]  RESET_ROW   = {MAX_SLOTS{CTR_RESET}};

  // configuration
  logic [SCNT_W-1:0]  slot_count;
  logic [SHIFT_W-1:0] pc_shift;

  // clearing sweep
  logic                clr_active;
  logic [ROW_BITS-1:0] clr_addr;

  // stage B: item waiting for its row data
  logic                b_valid;
  req_t                b_req;
  logic [ROW_BITS-1:0] b_row;
  logic [SLOT_W-1:0]   b_slot;
  logic                b_taken;
  logic                b_correct;
  logic                b_fwd;
  logic [ROW_W-1:0]    b_fwd_data;

  // statistics
  logic [STAT_W-1:0] hits       [MAX_SLOTS];
  logic [STAT_W-1:0] misses     [MAX_SLOTS];
  logic [STAT_W-1:0] hits_next  [MAX_SLOTS];
  logic [STAT_W-1:0] misses_next[MAX_SLOTS];

  // RAM ports
  logic                ram_we;
  logic [ROW_BITS-1:0] ram_waddr;
  logic [ROW_W-1:0]    ram_wdata;
  logic [ROW_W-1:0]    ram_rdata;

  logic                accept;
  logic                out_ready;
  logic                b_adv;
  logic [ROW_BITS-1:0] row_in;
  logic [ROW_W-1:0]    row_data;
  logic [ROW_W-1:0]    row_next;
  logic                upd_ok;
  logic [MASK_W-1:0]   mask_b;
  logic [STAT_W-1:0]   hit_sel;
  logic [STAT_W-1:0]   miss_sel;

  assign out_ready = !out_valid || !out_stall;
  assign b_adv     = b_valid && out_ready;
  assign in_stall  = clr_active || (b_valid && !out_ready);
  assign accept    = in_valid && !in_stall;

  assign row_in = ROW_BITS'((pc >> pc_shift) ^ history);

  assign row_data = b_fwd ? b_fwd_data : ram_rdata;
  assign upd_ok   = (b_req == REQ_UPDATE) && ({1'b0, b_slot} < slot_count) &&
                    ({1'b0, b_slot} < MAX_SLOTS_W);

  assign ram_we    = clr_active || (b_adv && upd_ok);
  assign ram_waddr = clr_active ? clr_addr : b_row;
  assign ram_wdata = clr_active ? RESET_ROW : row_next;

  mbgs_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (row_in),
    .rdata (ram_rdata)
  );

  // Per-slot prediction, counter step and statistics selection
  always_comb begin
    row_next = row_data;
    mask_b   = '0;
    hit_sel  = '0;
    miss_sel = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (SCNT_W'(i) < slot_count) begin
        mask_b[i] = row_data[2*i+1];
      end
      if (b_slot == SLOT_W'(i)) begin
        if (b_taken) begin
          if (row_data[2*i +: 2] != CTR_MAX) begin
            row_next[2*i +: 2] = row_data[2*i +: 2] + 2'd1;
          end
        end else if (row_data[2*i +: 2] != CTR_MIN) begin
          row_next[2*i +: 2] = row_data[2*i +: 2] - 2'd1;
        end
        hit_sel  = hits_next[i];
        miss_sel = misses_next[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      hits_next[i]   = hits[i];
      misses_next[i] = misses[i];
      if (upd_ok && (b_slot == SLOT_W'(i))) begin
        if (b_correct) begin
          if (hits[i] != STAT_MAX) begin
            hits_next[i] = hits[i] + 1'b1;
          end
        end else if (misses[i] != STAT_MAX) begin
          misses_next[i] = misses[i] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= SLOT_COUNT_RESET;
      pc_shift   <= PC_SHIFT_RESET;
      clr_active <= 1'b1;
      clr_addr   <= '0;
      b_valid    <= 1'b0;
      out_valid  <= 1'b0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        hits[i]   <= '0;
        misses[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SLOT_COUNT: slot_count <= cfg_data;
          CFG_PC_SHIFT:   pc_shift   <= cfg_data[SHIFT_W-1:0];
          default: ;
        endcase
      end

      // sweep the table to weakly taken
      if (clr_active) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == ROW_BITS'(ROWS - 1)) begin
          clr_active <= 1'b0;
        end
      end

      if (accept) begin
        b_valid <= 1'b1;
      end else if (b_adv) begin
        b_valid <= 1'b0;
      end

      out_valid <= b_adv || (out_valid && out_stall);

      if (b_adv) begin
        if (b_req == REQ_CLEAR) begin
          for (int i = 0; i < MAX_SLOTS; i++) begin
            hits[i]   <= '0;
            misses[i] <= '0;
          end
        end else begin
          for (int i = 0; i < MAX_SLOTS; i++) begin
            hits[i]   <= hits_next[i];
            misses[i] <= misses_next[i];
          end
        end
      end
    end

    // payload registers
    if (accept) begin
      b_req      <= req_t'(req_type);
      b_row      <= row_in;
      b_slot     <= slot_index;
      b_taken    <= outcome_taken;
      b_correct  <= prediction_correct;
      // bypass the row written on this same edge
      b_fwd      <= ram_we && (ram_waddr == row_in);
      b_fwd_data <= ram_wdata;
    end

    if (b_adv) begin
      taken_mask <= (b_req == REQ_PREDICT) ? mask_b : '0;
      hit_total  <= upd_ok ? hit_sel : '0;
      miss_total <= upd_ok ? miss_sel : '0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mbgs_checker.sv =====
// ----------------------------------------------------------------------------
// mbgs_checker
// Port-level checks of the multi-branch gshare predictor, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module mbgs_checker
  import mbgs_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [MASK_W-1:0] taken_mask,
  input wire logic [STAT_W-1:0] hit_total,
  input wire logic [STAT_W-1:0] miss_total
);

  // The table sweep holds off requests right after reset
  a_sweep_after_reset: assert property (@(posedge clk) rst |=> in_stall)
    else $error("request accepted during table sweep");

  a_no_result_after_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  // A result carries either a prediction mask or statistics, never both
  a_mask_or_stats: assert property (@(posedge clk) disable iff (rst)
    out_valid && (taken_mask != '0) |-> (hit_total == '0) && (miss_total == '0))
    else $error("result mixes prediction and statistics");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(taken_mask) &&
      $stable(hit_total) && $stable(miss_total))
    else $error("stalled result changed");

endmodule

bind multi_branch_gshare_predictor_top mbgs_checker u_mbgs_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .taken_mask (taken_mask),
  .hit_total  (hit_total),
  .miss_total (miss_total)
);

`default_nettype wire
